@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, ignored while reset is high.
`define MCRT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define MCRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mcrt_pkg.sv @@
// Shared types and constants of the reload timer bank.
package mcrt_pkg;

   localparam int CMD_W   = 2;
   localparam int CHAN_W  = 3;
   localparam int VALUE_W = 16;
   localparam int MASK_W  = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK         = 2'd0,
      CMD_START        = 2'd1,
      CMD_SET_INTERVAL = 2'd2
   } cmd_type;

   typedef struct packed {
      logic tick;
      logic start;
      logic set_interval;
      logic run_flag;
      logic one_shot;
   } chan_ctrl_type;

endpackage

@@ src/mcrt_if.sv @@
// Request and response channel interfaces of the reload timer bank.
interface mcrt_req_if;
   logic                             valid;
   logic                             ready;
   logic [mcrt_pkg::CMD_W-1:0]       cmd;
   logic [mcrt_pkg::CHAN_W-1:0]      channel;
   logic                             run_flag;
   logic                             one_shot;
   logic [mcrt_pkg::VALUE_W-1:0]     reload_value;

   modport source (output valid, cmd, channel, run_flag, one_shot, reload_value, input ready);
   modport sink   (input valid, cmd, channel, run_flag, one_shot, reload_value, output ready);
endinterface

interface mcrt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mcrt_pkg::MASK_W-1:0]      fired_mask;
   logic [mcrt_pkg::MASK_W-1:0]      running_mask;

   modport source (output valid, fired_mask, running_mask, input ready);
   modport sink   (input valid, fired_mask, running_mask, output ready);
endinterface

@@ src/mcrt_channel.sv @@
// One timer channel: interval, count, run and single-shot state.
module mcrt_channel #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mcrt_pkg::chan_ctrl_type    ctrl,
   input  logic [COUNT_WIDTH-1:0]     reload,
   output logic                       fired,
   output logic                       running_next
);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] interval_ff, interval_in;
   logic                   running_ff, running_in;
   logic                   single_ff, single_in;
   logic                   at_zero;

   assign at_zero = (count_ff == '0);
   assign fired   = ctrl.tick && running_ff && at_zero;

   always_comb begin
      count_in    = count_ff;
      interval_in = interval_ff;
      running_in  = running_ff;
      single_in   = single_ff;
      if (ctrl.tick && running_ff) begin
         if (at_zero) begin
            count_in   = interval_ff;
            running_in = !single_ff;
         end else begin
            count_in = count_ff - COUNT_WIDTH'(1);
         end
      end else if (ctrl.start) begin
         count_in   = interval_ff;
         running_in = ctrl.run_flag;
         single_in  = ctrl.one_shot;
      end else if (ctrl.set_interval) begin
         interval_in = reload;
      end
   end

   assign running_next = running_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         interval_ff <= '0;
         running_ff  <= 1'b0;
         single_ff   <= 1'b0;
      end else begin
         count_ff    <= count_in;
         interval_ff <= interval_in;
         running_ff  <= running_in;
         single_ff   <= single_in;
      end
   end

endmodule

@@ src/multi_channel_reload_timer_bank.sv @@
// Top level of the reload timer bank: command register, channel array, result register.
//
//   channel | dir | beat
//   req_if  | in  | cmd, channel, run_flag, one_shot, reload_value
//   rsp_if  | out | fired_mask, running_mask
//
// One command beat per cycle unless the response stalls; the response is registered.
// All channels update together as the command moves from the command register
// into the result register. Synchronous reset stops every channel and clears counts
// and intervals. A stalled response holds the result register; one more beat waits
// in the command register before req_if.ready drops.
module multi_channel_reload_timer_bank #(
   parameter int NUM_CHANNELS = 8,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic        clock,
   input  logic        reset,
   mcrt_req_if.sink    req_if,
   mcrt_rsp_if.source  rsp_if
);

   logic                              s1_valid_ff, s1_valid_in;
   mcrt_pkg::cmd_type                 s1_cmd_ff;
   logic [mcrt_pkg::CHAN_W-1:0]       s1_channel_ff;
   logic                              s1_run_ff;
   logic                              s1_one_ff;
   logic [mcrt_pkg::VALUE_W-1:0]      s1_reload_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mcrt_pkg::MASK_W-1:0]       fired_mask_ff, fired_mask_in;
   logic [mcrt_pkg::MASK_W-1:0]       running_mask_ff, running_mask_in;

   logic                              take;
   logic                              advance;
   logic [NUM_CHANNELS-1:0]           fired_vec;
   logic [NUM_CHANNELS-1:0]           running_vec;
   logic [COUNT_WIDTH-1:0]            reload_trim;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;
   assign reload_trim  = COUNT_WIDTH'(s1_reload_ff);

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      mcrt_pkg::chan_ctrl_type ctrl;
      logic                    hit;

      assign hit = (int'(s1_channel_ff) == c);

      always_comb begin
         ctrl = '0;
         ctrl.run_flag = s1_run_ff;
         ctrl.one_shot = s1_one_ff;
         if (advance) begin
            case (s1_cmd_ff)
               mcrt_pkg::CMD_TICK:         ctrl.tick = 1'b1;
               mcrt_pkg::CMD_START:        ctrl.start = hit;
               mcrt_pkg::CMD_SET_INTERVAL: ctrl.set_interval = hit;
               default:                    ctrl.tick = 1'b0;
            endcase
         end
      end

      mcrt_channel #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_channel (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .reload       (reload_trim),
         .fired        (fired_vec[c]),
         .running_next (running_vec[c])
      );
   end

   // channels beyond the mask width are not shown
   for (genvar b = 0; b < mcrt_pkg::MASK_W; b++) begin : g_mask
      if (b < NUM_CHANNELS) begin : g_on
         assign fired_mask_in[b]   = fired_vec[b];
         assign running_mask_in[b] = running_vec[b];
      end else begin : g_off
         assign fired_mask_in[b]   = 1'b0;
         assign running_mask_in[b] = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff     <= mcrt_pkg::cmd_type'(req_if.cmd);
         s1_channel_ff <= req_if.channel;
         s1_run_ff     <= req_if.run_flag;
         s1_one_ff     <= req_if.one_shot;
         s1_reload_ff  <= req_if.reload_value;
      end
      if (advance) begin
         fired_mask_ff   <= fired_mask_in;
         running_mask_ff <= running_mask_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.fired_mask   = fired_mask_ff;
   assign rsp_if.running_mask = running_mask_ff;

endmodule

@@ src/mcrt_checker.sv @@
// Port-level checks of the reload timer bank and their binding.
`include "assert_macros.svh"

module mcrt_checker #(
   parameter int NUM_CHANNELS = 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mcrt_pkg::MASK_W-1:0]   fired_mask,
   input logic [mcrt_pkg::MASK_W-1:0]   running_mask
);

   `MCRT_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "response beat right after reset")
   `MCRT_ASSERT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "stalled response beat dropped")
   `MCRT_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(fired_mask) && $stable(running_mask), "stalled response beat changed")
   `MCRT_ASSERT(a_mask_range, clock, reset, rsp_valid |-> ((fired_mask >> NUM_CHANNELS) == '0) && ((running_mask >> NUM_CHANNELS) == '0), "mask bit set for absent channel")

endmodule

bind multi_channel_reload_timer_bank mcrt_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_mcrt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .fired_mask   (rsp_if.fired_mask),
   .running_mask (rsp_if.running_mask)
);
